[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/lsac_pkg.sv]
package lsac_pkg;

  localparam int unsigned NUM_SETS = 4;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned WAY_W    = $clog2(NUM_WAYS);
  localparam int unsigned OFFS_W   = 4;
  localparam int unsigned TAG_LSB  = 6;
  localparam int unsigned TAG_W    = ADDR_W - TAG_LSB;
  localparam int unsigned STACK_W  = NUM_WAYS * WAY_W;
  localparam int unsigned CNT_W    = 16;

  localparam logic [STACK_W-1:0] STACK_RESET = 8'hE4;
  localparam logic [CNT_W-1:0]   HIT_MAX     = 16'hFFFF;

  // Result tdata layout, lowest bit first.
  localparam int unsigned OUT_WAY_LSB   = 0;
  localparam int unsigned OUT_SET_LSB   = OUT_WAY_LSB + WAY_W;
  localparam int unsigned OUT_TAG_LSB   = OUT_SET_LSB + SET_W;
  localparam int unsigned OUT_STACK_LSB = OUT_TAG_LSB + TAG_W;
  localparam int unsigned OUT_CNT_LSB   = OUT_STACK_LSB + STACK_W;
  localparam int unsigned OUT_BITS      = OUT_CNT_LSB + CNT_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [WAY_W-1:0]   way_t;
  typedef logic [SET_W-1:0]   set_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [STACK_W-1:0] stack_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

[rtl/lru_set_assoc_cache_lookup_top.sv]
// Tag lookup for a 4-way, 4-set cache with true LRU replacement. Each input item is a
// 32-bit byte address: bits 5:4 select the set, bits 31:6 are the tag. The result
// reports hit/miss, the way hit or filled (the least recent way on a miss), set, tag,
// the set's updated recency stack (bits 7:6 most recent way) and a saturating hit
// count. One item is accepted every cycle unless the output stalls; each item passes
// through the input register, then the single-pass compare/update into the result
// register. Valid bits and recency stacks reset at once; no clearing pass is needed.
module lru_set_assoc_cache_lookup_top
  import lsac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [ADDR_W-1:0]     s_axis_tdata_i,   // address
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // way_used, set_index, tag_value,
                                                  // recency_stack, hit_total, zero pad
  output logic                  m_axis_tuser_o    // hit
);

  logic                      in_vld_q, in_vld_d;
  logic [ADDR_W-1:0]         addr_q, addr_d;
  logic                      out_vld_q, out_vld_d;
  logic                      out_hit_q, out_hit_d;
  logic [OUT_DATA_W-1:0]     out_data_q, out_data_d;

  logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_q, valid_d;
  stack_t                    stack_q [NUM_SETS];
  tag_t                      tag_q   [NUM_SETS][NUM_WAYS];
  cnt_t                      cnt_q, cnt_d;

  logic                      advance;
  set_t                      set_idx;
  tag_t                      tag;
  stack_t                    st_old, st_new;
  way_t                      s0, s1, s2, s3;
  logic [NUM_WAYS-1:0]       match;
  logic                      hit;
  way_t                      way;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;

  always_comb begin
    set_idx = addr_q[OFFS_W +: SET_W];
    tag     = addr_q[ADDR_W-1:TAG_LSB];
    st_old  = stack_q[set_idx];
    s0      = st_old[0*WAY_W +: WAY_W];
    s1      = st_old[1*WAY_W +: WAY_W];
    s2      = st_old[2*WAY_W +: WAY_W];
    s3      = st_old[3*WAY_W +: WAY_W];
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = valid_q[set_idx][w] && (tag_q[set_idx][w] == tag);
    end
    hit = |match;
    way = s0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        way = way_t'(w);
      end
    end
    if (!hit || way == s0) begin
      st_new = {s0, s3, s2, s1};
    end else if (way == s1) begin
      st_new = {s1, s3, s2, s0};
    end else if (way == s2) begin
      st_new = {s2, s3, s1, s0};
    end else begin
      st_new = st_old;
    end
  end

  always_comb begin
    in_vld_d   = in_vld_q;
    addr_d     = addr_q;
    out_vld_d  = out_vld_q;
    out_hit_d  = out_hit_q;
    out_data_d = out_data_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (advance) begin
      in_vld_d = 1'b0;
      if (hit && cnt_q != HIT_MAX) begin
        cnt_d = cnt_q + cnt_t'(1);
      end
      if (!hit) begin
        valid_d[set_idx][way] = 1'b1;
      end
      out_vld_d  = 1'b1;
      out_hit_d  = hit;
      out_data_d = '0;
      out_data_d[OUT_WAY_LSB   +: WAY_W]   = way;
      out_data_d[OUT_SET_LSB   +: SET_W]   = set_idx;
      out_data_d[OUT_TAG_LSB   +: TAG_W]   = tag;
      out_data_d[OUT_STACK_LSB +: STACK_W] = st_new;
      out_data_d[OUT_CNT_LSB   +: CNT_W]   = cnt_d;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_d = 1'b1;
      addr_d   = s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
      cnt_q     <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        stack_q[s] <= STACK_RESET;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      if (advance) begin
        stack_q[set_idx] <= st_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    out_hit_q  <= out_hit_d;
    out_data_q <= out_data_d;
    if (advance && !hit) begin
      tag_q[set_idx][way] <= tag;
    end
  end

endmodule

[rtl/lsac_checker.sv]
`include "assert_macros.svh"

module lsac_checker
  import lsac_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [ADDR_W-1:0]     s_axis_tdata_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  way_t   way_o;
  way_t   mru_o;
  stack_t st_o;
  logic   out_stall;
  logic   stack_dup;
  logic [OUT_DATA_W-OUT_BITS-1:0] pad_o;

  assign way_o     = m_axis_tdata_o[OUT_WAY_LSB +: WAY_W];
  assign st_o      = m_axis_tdata_o[OUT_STACK_LSB +: STACK_W];
  assign mru_o     = st_o[STACK_W-1 -: WAY_W];
  assign pad_o     = m_axis_tdata_o[OUT_DATA_W-1:OUT_BITS];
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign stack_dup = (st_o[1:0] == st_o[3:2]) || (st_o[1:0] == st_o[5:4]) ||
                     (st_o[1:0] == st_o[7:6]) || (st_o[3:2] == st_o[5:4]) ||
                     (st_o[3:2] == st_o[7:6]) || (st_o[5:4] == st_o[7:6]);

  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid_o, "result dropped while stalled")

  `ASSERT_CLK(a_used_way_mru, m_axis_tvalid_o |-> mru_o == way_o, "used way is not most recent")

  `ASSERT_NEVER(a_stack_perm, m_axis_tvalid_o && stack_dup, "recency stack is not a permutation")

  `ASSERT_CLK(a_pad_zero, m_axis_tvalid_o |-> pad_o == '0, "pad bits not zero")

endmodule

bind lru_set_assoc_cache_lookup_top lsac_checker u_lsac_checker (.*);
